// File: design/cdt_pkg.sv
// shared types and constants for the clock drift tracker
package cdt_pkg;

  localparam int MEDIAN_TAPS       = 5;
  localparam int STABLE_RUN_NEEDED = 5;
  localparam int RING_IDX_W        = $clog2(MEDIAN_TAPS);

  localparam logic [29:0] NS_PER_S   = 30'd1000000000;
  localparam logic [63:0] FREEZE_NS  = 64'd10000000000;
  localparam logic [29:0] PPM_SCALE  = 30'd1000000;
  localparam logic [63:0] RATE_CAP   = 64'h3FFF_FFFF_FFFF_FFFF;

  typedef logic [MEDIAN_TAPS-1:0][31:0] ring_t;

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_NOT_DUE  = 3'd1,
    ST_PRIMED   = 3'd2,
    ST_OUTLIER  = 3'd3,
    ST_MEASURED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CFG_ENABLE     = 3'd0,
    CFG_RATE       = 3'd1,
    CFG_RATIO_MIN  = 3'd2,
    CFG_RATIO_MAX  = 3'd3,
    CFG_STAB_ABS   = 3'd4,
    CFG_STAB_DELTA = 3'd5,
    CFG_FAST       = 3'd6,
    CFG_SLOW       = 3'd7
  } cfg_idx_t;

  // pre-shift applied to the product before dividing
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_30   = 2'd1,
    SH_32   = 2'd2
  } shift_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [29:0] b;
    shift_t      shift;
    logic [63:0] d;
  } md_req_t;

  typedef struct packed {
    logic  start;
    logic  is_signed;
    ring_t vals;
  } sort_req_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV
  } md_state_t;

  typedef enum logic [1:0] {
    SO_IDLE,
    SO_RUN,
    SO_DONE
  } sort_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_GEN,
    S_DECIDE,
    S_RA_GO,
    S_RA_WAIT,
    S_RR_GO,
    S_RR_WAIT,
    S_DR_GO,
    S_DR_WAIT,
    S_RT_SEL,
    S_RT_WAIT,
    S_GATE_A,
    S_GATE_B,
    S_RING,
    S_MP_GO,
    S_MP_WAIT,
    S_MR_GO,
    S_MR_WAIT,
    S_HINT,
    S_STAB,
    S_FIN
  } top_state_t;

endpackage

// File: design/clock_drift_tracker_core.sv
// top level of the clock drift tracker: sequencer, state and result register
//
// usage: one request on the input channel is one report call (time, local and
// network frame/stamp snapshots, resync generation). each request yields
// exactly one result on the output channel. both channels move a request at a
// rising edge where valid is high and stall is low.
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, write only while the block is idle.
// flow: a disabled, not-due or primed-only report goes from acceptance through
// the GEN and DECIDE states to FIN. a full measurement runs up to four
// multiply/divide jobs on the one shared unit (each: 30 multiply steps, one
// range check, then 64 divide steps unless the check saturates) plus, once the
// ring is full, two 16-step median sorts.
// throughput: one request at a time; in_stall is high from acceptance until
// the result is placed in the output register.
// the output register lets a new request be accepted while the previous result
// still waits on out_stall; a finished result holds the sequencer until the
// output register is free.
// reset: all tracking state except the ring contents clears, the hint returns to 1.0 and the
// configuration registers take their reset values; no clearing pass is needed.
module clock_drift_tracker_core import cdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [62:0]        now_time_ns,
  input  logic [62:0]        local_frames,
  input  logic [62:0]        local_stamp_ns,
  input  logic [62:0]        net_frames,
  input  logic [62:0]        net_stamp_ns,
  input  logic [31:0]        resync_generation,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic signed [31:0] drift_ppm_q16,
  output logic [31:0]        ratio_q30,
  output logic [31:0]        ratio_hint_q30,
  output logic               hint_updated,
  output logic               stabilized,
  output logic               frozen
);

  // configuration registers
  logic        report_enable;
  logic [17:0] sample_rate_hz;
  logic [31:0] ratio_min_q30, ratio_max_q30;
  logic [22:0] stable_abs_ppm_q16, stable_delta_ppm_q16;
  logic [7:0]  fast_period_s, slow_period_s;

  // tracking state
  logic [63:0] prev_local_frames, prev_local_stamp, prev_net_frames, prev_net_stamp;
  logic [63:0] next_due_ns, freeze_until_ns;
  logic [31:0] last_generation;
  ring_t       ppm_ring, ratio_ring;
  logic [RING_IDX_W-1:0] ring_index;
  logic [RING_IDX_W:0]   ring_fill;
  logic [2:0]  stable_run;
  logic        stable_flag;
  logic [31:0] prev_median_ppm;
  logic [31:0] hint_register;

  // latched request
  logic [63:0] now_r, lfr_r, lts_r, nfr_r, nts_r;
  logic [31:0] gen_r;

  // working registers
  top_state_t  state, state_next;
  logic [63:0] dfr_a, dts_a, dfr_r, dts_r;
  logic signed [63:0] ar, rr;
  logic        diff_neg;
  logic [31:0] drift, ratio, dmed, rmed;
  logic        ok_a, sample_ok;
  logic        frozen_r;
  status_t     res_status;
  logic        res_upd;

  // unit handshakes
  md_req_t     md_req;
  logic        md_done;
  logic [63:0] md_q;
  sort_req_t   so_req;
  logic        so_done;
  logic [31:0] so_med;

  cdt_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .done (md_done),
    .q    (md_q)
  );

  cdt_sort u_sort (
    .clk    (clk),
    .rst    (rst),
    .req    (so_req),
    .done   (so_done),
    .median (so_med)
  );

  function automatic logic [63:0] secs_to_ns(input logic [7:0] s);
    logic [37:0] p;
    p = 38'(s) * 38'(NS_PER_S);
    return 64'(p);
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // rate within +-5 percent of nominal
  function automatic logic rate_ok(input logic [63:0] r, input logic [17:0] sr);
    logic [63:0] u, lo_b, hi_b;
    u    = (r << 4) + (r << 2);
    lo_b = 64'(23'(sr) * 23'd19) << 32;
    hi_b = 64'(23'(sr) * 23'd21) << 32;
    return !r[63] && (r != 64'd0) && (r[62:57] == 6'd0) && (u > lo_b) && (u < hi_b);
  endfunction

  // rate magnitude capped, then the sign of the frame delta
  function automatic logic [63:0] signed_rate(input logic [63:0] q, input logic neg);
    logic [63:0] c;
    c = (q > RATE_CAP) ? RATE_CAP : q;
    return neg ? (~c + 64'd1) : c;
  endfunction

  // median stability terms
  logic [32:0] abs_dmed;
  logic [33:0] dd, abs_dd;
  logic        stab_ok;
  logic [2:0]  run_next;
  logic [63:0] diff;
  logic [63:0] drift_div;
  logic        window_ok;
  logic        ratio_special;

  assign abs_dmed = dmed[31] ? (~{1'b1, dmed} + 33'd1) : {1'b0, dmed};
  assign dd       = {{2{dmed[31]}}, dmed} - {{2{prev_median_ppm[31]}}, prev_median_ppm};
  assign abs_dd   = dd[33] ? (~dd + 34'd1) : dd;
  assign stab_ok  = (abs_dmed < {10'd0, stable_abs_ppm_q16}) &&
                    (abs_dd < {11'd0, stable_delta_ppm_q16});
  assign run_next = stab_ok ? ((stable_run < 3'd7) ? stable_run + 3'd1 : stable_run)
                            : 3'd0;
  assign diff      = ar - rr;
  assign drift_div = {30'd0, ((sample_rate_hz != 18'd0) ? sample_rate_hz : 18'd1), 16'd0};
  assign window_ok = (prev_local_stamp != 64'd0) && (prev_net_stamp != 64'd0) &&
                     (lts_r > prev_local_stamp) && (nts_r > prev_net_stamp);
  assign ratio_special = (ar == 64'sd0) || (rr == 64'sd0) || (ar[63] != rr[63]);

  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_GEN;
      S_GEN:     state_next = S_DECIDE;
      S_DECIDE: begin
        if (!report_enable || (now_r < next_due_ns) || !window_ok) state_next = S_FIN;
        else state_next = S_RA_GO;
      end
      S_RA_GO:   state_next = S_RA_WAIT;
      S_RA_WAIT: if (md_done) state_next = S_RR_GO;
      S_RR_GO:   state_next = S_RR_WAIT;
      S_RR_WAIT: if (md_done) state_next = S_DR_GO;
      S_DR_GO:   state_next = S_DR_WAIT;
      S_DR_WAIT: if (md_done) state_next = S_RT_SEL;
      S_RT_SEL:  state_next = ratio_special ? S_GATE_A : S_RT_WAIT;
      S_RT_WAIT: if (md_done) state_next = S_GATE_A;
      S_GATE_A:  state_next = S_GATE_B;
      S_GATE_B:  state_next = S_RING;
      S_RING:    state_next = (ring_fill == (RING_IDX_W+1)'(MEDIAN_TAPS)) ? S_MP_GO : S_HINT;
      S_MP_GO:   state_next = S_MP_WAIT;
      S_MP_WAIT: if (so_done) state_next = S_MR_GO;
      S_MR_GO:   state_next = S_MR_WAIT;
      S_MR_WAIT: if (so_done) state_next = S_HINT;
      S_HINT:    state_next = S_STAB;
      S_STAB:    state_next = S_FIN;
      S_FIN:     if (!out_valid || !out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and unit requests
  always_comb begin
    in_stall     = (state != S_IDLE);
    md_req       = '0;
    md_req.shift = SH_NONE;
    so_req       = '0;
    unique case (state)
      S_RA_GO: begin
        md_req.start = 1'b1;
        md_req.a     = abs64(dfr_a);
        md_req.b     = NS_PER_S;
        md_req.shift = SH_32;
        md_req.d     = dts_a;
      end
      S_RR_GO: begin
        md_req.start = 1'b1;
        md_req.a     = abs64(dfr_r);
        md_req.b     = NS_PER_S;
        md_req.shift = SH_32;
        md_req.d     = dts_r;
      end
      S_DR_GO: begin
        md_req.start = 1'b1;
        md_req.a     = abs64(diff);
        md_req.b     = PPM_SCALE;
        md_req.shift = SH_NONE;
        md_req.d     = drift_div;
      end
      S_RT_SEL: begin
        md_req.start = !ratio_special;
        md_req.a     = abs64(rr);
        md_req.b     = 30'd1;
        md_req.shift = SH_30;
        md_req.d     = abs64(ar);
      end
      S_MP_GO: begin
        so_req.start     = 1'b1;
        so_req.is_signed = 1'b1;
        so_req.vals      = ppm_ring;
      end
      S_MR_GO: begin
        so_req.start     = 1'b1;
        so_req.is_signed = 1'b0;
        so_req.vals      = ratio_ring;
      end
      default: ;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      report_enable        <= 1'b1;
      sample_rate_hz       <= 18'd48000;
      ratio_min_q30        <= 32'd1072668082;
      ratio_max_q30        <= 32'd1074815566;
      stable_abs_ppm_q16   <= 23'd196608;
      stable_delta_ppm_q16 <= 23'd131072;
      fast_period_s        <= 8'd5;
      slow_period_s        <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ENABLE:     report_enable        <= cfg_data[0];
        CFG_RATE:       sample_rate_hz       <= cfg_data[17:0];
        CFG_RATIO_MIN:  ratio_min_q30        <= cfg_data;
        CFG_RATIO_MAX:  ratio_max_q30        <= cfg_data;
        CFG_STAB_ABS:   stable_abs_ppm_q16   <= cfg_data[22:0];
        CFG_STAB_DELTA: stable_delta_ppm_q16 <= cfg_data[22:0];
        CFG_FAST:       fast_period_s        <= cfg_data[7:0];
        CFG_SLOW:       slow_period_s        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state and tracking state
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      prev_local_frames <= '0;
      prev_local_stamp  <= '0;
      prev_net_frames   <= '0;
      prev_net_stamp    <= '0;
      next_due_ns       <= '0;
      freeze_until_ns   <= '0;
      last_generation   <= '0;
      ring_index        <= '0;
      ring_fill         <= '0;
      stable_run        <= '0;
      stable_flag       <= 1'b0;
      prev_median_ppm   <= '0;
      hint_register     <= 32'd1073741824;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_GEN: if (gen_r != last_generation) begin
          // resync: freeze and restart tracking
          last_generation   <= gen_r;
          freeze_until_ns   <= now_r + FREEZE_NS;
          ring_index        <= '0;
          ring_fill         <= '0;
          stable_run        <= '0;
          stable_flag       <= 1'b0;
          prev_median_ppm   <= '0;
          prev_local_frames <= '0;
          prev_local_stamp  <= '0;
          prev_net_frames   <= '0;
          prev_net_stamp    <= '0;
          next_due_ns       <= now_r + secs_to_ns(fast_period_s);
        end
        S_DECIDE: begin
          if (!report_enable) begin
            next_due_ns <= now_r + secs_to_ns(slow_period_s);
          end else if (now_r >= next_due_ns) begin
            // snapshots taken after the deltas are latched
            prev_local_frames <= lfr_r;
            prev_local_stamp  <= lts_r;
            prev_net_frames   <= nfr_r;
            prev_net_stamp    <= nts_r;
            next_due_ns <= now_r + secs_to_ns(stable_flag ? slow_period_s
                                                          : fast_period_s);
          end
        end
        S_GATE_B: if (ok_a && rate_ok(rr, sample_rate_hz)) begin
          ppm_ring[ring_index]   <= drift;
          ratio_ring[ring_index] <= ratio;
          ring_index <= (ring_index == RING_IDX_W'(MEDIAN_TAPS - 1))
                        ? '0 : ring_index + RING_IDX_W'(1);
          if (ring_fill < (RING_IDX_W+1)'(MEDIAN_TAPS))
            ring_fill <= ring_fill + (RING_IDX_W+1)'(1);
        end
        S_HINT: if (!frozen_r && (rmed > ratio_min_q30) && (rmed < ratio_max_q30)) begin
          hint_register <= rmed;
        end
        S_STAB: if (!stable_flag) begin
          stable_run      <= run_next;
          prev_median_ppm <= dmed;
          if (run_next >= 3'(STABLE_RUN_NEEDED)) stable_flag <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // request payload and working values
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (in_valid) begin
        now_r      <= {1'b0, now_time_ns};
        lfr_r      <= {1'b0, local_frames};
        lts_r      <= {1'b0, local_stamp_ns};
        nfr_r      <= {1'b0, net_frames};
        nts_r      <= {1'b0, net_stamp_ns};
        gen_r      <= resync_generation;
        res_upd    <= 1'b0;
        drift      <= '0;
        ratio      <= '0;
        dmed       <= '0;
        rmed       <= '0;
      end
      S_DECIDE: begin
        frozen_r   <= (now_r < freeze_until_ns);
        dfr_a      <= lfr_r - prev_local_frames;
        dts_a      <= lts_r - prev_local_stamp;
        dfr_r      <= nfr_r - prev_net_frames;
        dts_r      <= nts_r - prev_net_stamp;
        if (!report_enable) res_status <= ST_DISABLED;
        else if (now_r < next_due_ns) res_status <= ST_NOT_DUE;
        else res_status <= ST_PRIMED;
      end
      S_RA_WAIT: if (md_done) ar <= signed_rate(md_q, dfr_a[63]);
      S_RR_WAIT: if (md_done) rr <= signed_rate(md_q, dfr_r[63]);
      S_DR_GO:   diff_neg <= diff[63];
      S_DR_WAIT: if (md_done) begin
        // drift saturated to int32
        if (diff_neg) drift <= (md_q > 64'h8000_0000) ? 32'h8000_0000 : (~md_q[31:0] + 32'd1);
        else drift <= (md_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : md_q[31:0];
      end
      S_RT_SEL: if (ar == 64'sd0) ratio <= '1;
                else if (ratio_special) ratio <= '0;
      S_RT_WAIT: if (md_done) ratio <= (md_q > 64'hFFFF_FFFF) ? '1 : md_q[31:0];
      S_GATE_A: ok_a <= rate_ok(ar, sample_rate_hz);
      S_GATE_B: begin
        sample_ok <= ok_a && rate_ok(rr, sample_rate_hz);
        dmed      <= drift;
        rmed      <= ratio;
      end
      S_MP_WAIT: if (so_done) dmed <= so_med;
      S_MR_WAIT: if (so_done) rmed <= so_med;
      S_HINT: res_upd <= !frozen_r && (rmed > ratio_min_q30) && (rmed < ratio_max_q30);
      S_STAB: res_status <= sample_ok ? ST_MEASURED : ST_OUTLIER;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || !out_stall)) begin
      status         <= res_status;
      drift_ppm_q16  <= (res_status == ST_OUTLIER || res_status == ST_MEASURED) ? dmed : '0;
      ratio_q30      <= (res_status == ST_OUTLIER || res_status == ST_MEASURED) ? rmed : '0;
      ratio_hint_q30 <= hint_register;
      hint_updated   <= (res_status == ST_OUTLIER || res_status == ST_MEASURED) && res_upd;
      stabilized     <= stable_flag;
      frozen         <= frozen_r;
    end
  end

endmodule

// File: design/cdt_muldiv.sv
// shared serial multiply then restoring divide unit, quotient saturated to 64 bits
module cdt_muldiv import cdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  md_req_t     req,
  output logic        done,
  output logic [63:0] q
);

  md_state_t   state, state_next;
  logic [63:0] a_r, d_r, rem, lo;
  logic [29:0] b_r;
  shift_t      sh_r;
  logic [93:0] prod;
  logic [5:0]  cnt;
  logic [127:0] n_full;
  logic [64:0] r2;
  logic        ge;
  logic        done_r;

  always_comb begin
    unique case (sh_r)
      SH_30:   n_full = {34'd0, prod} << 30;
      SH_32:   n_full = {34'd0, prod} << 32;
      default: n_full = {34'd0, prod};
    endcase
  end

  assign r2 = {rem, lo[63]};
  assign ge = (r2 >= {1'b0, d_r});

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (req.start) state_next = MD_MUL;
      MD_MUL:  if (cnt == 6'd0) state_next = MD_CHK;
      MD_CHK:  if (n_full[127:64] < d_r) state_next = MD_DIV;
               else state_next = MD_IDLE;
      MD_DIV:  if (cnt == 6'd0) state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_comb begin
    done = done_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      state  <= state_next;
      done_r <= ((state == MD_CHK) && (n_full[127:64] >= d_r)) ||
                ((state == MD_DIV) && (cnt == 6'd0));
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: if (req.start) begin
        a_r  <= req.a;
        b_r  <= req.b;
        sh_r <= req.shift;
        d_r  <= req.d;
        prod <= '0;
        cnt  <= 6'd29;
      end
      MD_MUL: begin
        prod <= (prod << 1) + (b_r[cnt[4:0]] ? {30'd0, a_r} : 94'd0);
        cnt  <= cnt - 6'd1;
      end
      MD_CHK: begin
        rem <= n_full[127:64];
        lo  <= n_full[63:0];
        cnt <= 6'd63;
        if (n_full[127:64] >= d_r) q <= '1;
        else q <= '0;
      end
      MD_DIV: begin
        rem <= ge ? 64'(r2 - {1'b0, d_r}) : r2[63:0];
        lo  <= lo << 1;
        q   <= {q[62:0], ge};
        cnt <= cnt - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

// File: design/cdt_sort.sv
// median of the window by bubble sort through one shared comparator
module cdt_sort import cdt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  sort_req_t   req,
  output logic        done,
  output logic [31:0] median
);

  localparam int IW = $clog2(MEDIAN_TAPS);
  localparam logic [IW-1:0] LAST = IW'(MEDIAN_TAPS - 2);

  sort_state_t   state, state_next;
  ring_t         w;
  logic          sgn_r;
  logic [IW-1:0] j, pass, jp1;
  logic [31:0]   x, y;
  logic          swap;
  logic          last_step;

  assign jp1       = j + IW'(1);
  assign x         = w[j];
  assign y         = w[jp1];
  // signed compare by flipping the sign bit when is_signed, plain unsigned otherwise
  assign swap      = ({x[31] ^ sgn_r, x[30:0]} > {y[31] ^ sgn_r, y[30:0]});
  assign last_step = (j == LAST) && (pass == LAST);

  always_comb begin
    state_next = state;
    unique case (state)
      SO_IDLE: if (req.start) state_next = SO_RUN;
      SO_RUN:  if (last_step) state_next = SO_DONE;
      SO_DONE: state_next = SO_IDLE;
      default: state_next = SO_IDLE;
    endcase
  end

  always_comb begin
    done   = (state == SO_DONE);
    median = w[MEDIAN_TAPS/2];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= SO_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (state == SO_IDLE && req.start) begin
      w     <= req.vals;
      sgn_r <= req.is_signed;
      j     <= '0;
      pass  <= '0;
    end else if (state == SO_RUN) begin
      if (swap) begin
        w[j]   <= y;
        w[jp1] <= x;
      end
      if (j == LAST) begin
        j    <= '0;
        pass <= pass + IW'(1);
      end else begin
        j <= jp1;
      end
    end
  end

endmodule

// File: dv/cdt_checker.sv
// report checker: predicts each drift report from accepted requests and compares results
`timescale 1ns / 100ps
module cdt_checker import cdt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [62:0]        now_time_ns,
  input  logic [62:0]        local_frames,
  input  logic [62:0]        local_stamp_ns,
  input  logic [62:0]        net_frames,
  input  logic [62:0]        net_stamp_ns,
  input  logic [31:0]        resync_generation,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [2:0]         status,
  input  logic signed [31:0] drift_ppm_q16,
  input  logic [31:0]        ratio_q30,
  input  logic [31:0]        ratio_hint_q30,
  input  logic               hint_updated,
  input  logic               stabilized,
  input  logic               frozen,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic [2:0]  st;
    logic [31:0] drift;
    logic [31:0] ratio;
    logic [31:0] hint;
    logic        upd;
    logic        stab;
    logic        frz;
  } report_t;

  report_t report_q[$];

  // configuration shadow
  logic        en;
  logic [17:0] sr;
  logic [31:0] rmin, rmax;
  logic [22:0] stab_abs, stab_delta;
  logic [7:0]  fast_s, slow_s;

  // tracking state
  logic [63:0] p_lfr, p_lts, p_nfr, p_nts, due_ns, freeze_ns;
  logic [31:0] last_gen;
  logic [31:0] ppm_ring [MEDIAN_TAPS];
  logic [31:0] ratio_ring [MEDIAN_TAPS];
  int          ring_idx, ring_fill, stab_run;
  logic        stab_flag;
  logic [31:0] prev_med, hint;

  assign pending = report_q.size();

  // signed Q32.32 frame rate, magnitude capped
  function automatic longint frame_rate(logic [63:0] dfr, logic [63:0] dts);
    logic [127:0] q;
    logic [63:0]  mag;
    mag = dfr[63] ? -dfr : dfr;
    q = ({64'd0, mag} * (128'd1000000000 << 32)) / {64'd0, dts};
    if (q > {64'd0, RATE_CAP}) q = {64'd0, RATE_CAP};
    return dfr[63] ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  // within 5 percent of nominal
  function automatic bit near_nominal(longint r, logic [63:0] rate_hz);
    logic [63:0] u;
    if (r <= 0 || r >= (longint'(1) << 57)) return 1'b0;
    u = 64'(r) * 20;
    return u > ((rate_hz * 19) << 32) && u < ((rate_hz * 21) << 32);
  endfunction

  function automatic longint median5(logic [31:0] ring [MEDIAN_TAPS], bit sgn);
    longint a [MEDIAN_TAPS];
    longint t;
    for (int i = 0; i < MEDIAN_TAPS; i++)
      a[i] = sgn ? longint'($signed(ring[i])) : longint'(ring[i]);
    for (int i = 0; i < MEDIAN_TAPS; i++)
      for (int j = 0; j < MEDIAN_TAPS - 1 - i; j++)
        if (a[j] > a[j+1]) begin
          t = a[j]; a[j] = a[j+1]; a[j+1] = t;
        end
    return a[MEDIAN_TAPS/2];
  endfunction

  task automatic predict_report();
    logic [63:0] now, lfr, lts, nfr, nts, interval, mag, den, rm, lm;
    logic [127:0] q;
    longint lr, nr, diff, drift, dmed, dd;
    logic [31:0] ratio;
    logic [63:0] rmed;
    bit ok;
    report_t e;
    now = {1'b0, now_time_ns};
    lfr = {1'b0, local_frames};
    lts = {1'b0, local_stamp_ns};
    nfr = {1'b0, net_frames};
    nts = {1'b0, net_stamp_ns};
    e = '{st: ST_PRIMED, drift: 0, ratio: 0, hint: 0, upd: 0, stab: 0, frz: 0};
    // resync: freeze and start over
    if (resync_generation != last_gen) begin
      last_gen = resync_generation;
      freeze_ns = now + FREEZE_NS;
      ring_idx = 0; ring_fill = 0; stab_run = 0; stab_flag = 0; prev_med = 0;
      p_lfr = 0; p_lts = 0; p_nfr = 0; p_nts = 0;
      due_ns = now + 64'(fast_s) * 64'd1000000000;
    end
    e.frz = now < freeze_ns;
    if (!en) begin
      due_ns = now + 64'(slow_s) * 64'd1000000000;
      e.st = ST_DISABLED;
    end else if (now < due_ns) begin
      e.st = ST_NOT_DUE;
    end else begin
      interval = stab_flag ? 64'(slow_s) : 64'(fast_s);
      if (p_lts > 0 && p_nts > 0 && lts > p_lts && nts > p_nts) begin
        lr = frame_rate(lfr - p_lfr, lts - p_lts);
        nr = frame_rate(nfr - p_nfr, nts - p_nts);
        diff = lr - nr;
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        den = (sr == 0) ? 64'd65536 : (64'(sr) << 16);
        q = ({64'd0, mag} * 128'd1000000) / {64'd0, den};
        if (diff < 0) drift = q > 128'h80000000 ? -longint'(64'h80000000) : -longint'(q[63:0]);
        else drift = q > 128'h7FFFFFFF ? longint'(64'h7FFFFFFF) : longint'(q[63:0]);
        // network over local ratio
        if (lr == 0) ratio = 32'hFFFFFFFF;
        else if (nr == 0 || ((lr < 0) != (nr < 0))) ratio = 0;
        else begin
          rm = nr < 0 ? 64'(-nr) : 64'(nr);
          lm = lr < 0 ? 64'(-lr) : 64'(lr);
          q = ({64'd0, rm} << 30) / {64'd0, lm};
          ratio = q > 128'hFFFFFFFF ? 32'hFFFFFFFF : q[31:0];
        end
        ok = near_nominal(lr, 64'(sr)) && near_nominal(nr, 64'(sr));
        if (ok) begin
          ppm_ring[ring_idx] = drift[31:0];
          ratio_ring[ring_idx] = ratio;
          ring_idx = (ring_idx + 1) % MEDIAN_TAPS;
          if (ring_fill < MEDIAN_TAPS) ring_fill++;
        end
        if (ring_fill == MEDIAN_TAPS) begin
          dmed = median5(ppm_ring, 1'b1);
          rmed = 64'(median5(ratio_ring, 1'b0));
        end else begin
          dmed = drift;
          rmed = {32'd0, ratio};
        end
        if (!e.frz && rmed > 64'(rmin) && rmed < 64'(rmax)) begin
          hint = rmed[31:0];
          e.upd = 1;
        end
        if (!stab_flag) begin
          dd = dmed - longint'($signed(prev_med));
          if ((dmed < 0 ? -dmed : dmed) < longint'(stab_abs) &&
              (dd < 0 ? -dd : dd) < longint'(stab_delta)) begin
            if (stab_run < 7) stab_run++;
          end else begin
            stab_run = 0;
          end
          prev_med = dmed[31:0];
          if (stab_run >= STABLE_RUN_NEEDED) stab_flag = 1;
        end
        e.drift = dmed[31:0];
        e.ratio = rmed[31:0];
        e.st = ok ? ST_MEASURED : ST_OUTLIER;
      end
      p_lfr = lfr; p_lts = lts; p_nfr = nfr; p_nts = nts;
      due_ns = now + interval * 64'd1000000000;
    end
    e.hint = hint;
    e.stab = stab_flag;
    report_q.push_back(e);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    report_t e;
    if (rst) begin
      en <= 1; sr <= 48000; rmin <= 32'd1072668082; rmax <= 32'd1074815566;
      stab_abs <= 196608; stab_delta <= 131072; fast_s <= 5; slow_s <= 30;
      p_lfr = 0; p_lts = 0; p_nfr = 0; p_nts = 0; due_ns = 0; freeze_ns = 0;
      last_gen = 0; ring_idx = 0; ring_fill = 0; stab_run = 0; stab_flag = 0;
      prev_med = 0; hint = 32'd1073741824;
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:     en <= cfg_data[0];
          CFG_RATE:       sr <= cfg_data[17:0];
          CFG_RATIO_MIN:  rmin <= cfg_data;
          CFG_RATIO_MAX:  rmax <= cfg_data;
          CFG_STAB_ABS:   stab_abs <= cfg_data[22:0];
          CFG_STAB_DELTA: stab_delta <= cfg_data[22:0];
          CFG_FAST:       fast_s <= cfg_data[7:0];
          CFG_SLOW:       slow_s <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_report();
      if (out_valid && !out_stall) begin
        if (report_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          e = report_q.pop_front();
          check_field("status", 32'(e.st), 32'(status));
          check_field("drift_ppm_q16", e.drift, drift_ppm_q16);
          check_field("ratio_q30", e.ratio, ratio_q30);
          check_field("ratio_hint_q30", e.hint, ratio_hint_q30);
          check_field("hint_updated", 32'(e.upd), 32'(hint_updated));
          check_field("stabilized", 32'(e.stab), 32'(stabilized));
          check_field("frozen", 32'(e.frz), 32'(frozen));
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// File: dv/clock_drift_tracker_core_tb.sv
// testbench top: drives report requests and configuration, gives the verdict
`timescale 1ns / 100ps
module clock_drift_tracker_core_tb import cdt_pkg::*;;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [62:0] now_time_ns = '0, local_frames = '0, local_stamp_ns = '0;
  logic [62:0] net_frames = '0, net_stamp_ns = '0;
  logic [31:0] resync_generation = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  status;
  logic signed [31:0] drift_ppm_q16;
  logic [31:0] ratio_q30, ratio_hint_q30;
  logic        hint_updated, stabilized, frozen;
  int          fail_count, pending;

  // idling on/off for both sides, long receiver hold-off request
  bit          idle_on = 1;
  bit          hold_req = 0;

  // sender's own view of the local and network clocks
  logic [63:0] t_now, l_fr, l_ts, n_fr, n_ts;
  logic [31:0] gen;
  int          cur_sr, cur_fast, cur_slow;

  always #10 clk = ~clk;

  clock_drift_tracker_core u_dut (.*);

  cdt_checker u_chk (.*);

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic [62:0] rand63();
    return 63'({$urandom, $urandom});
  endfunction

  // receiver stall pattern, with one long counted hold-off on request
  initial begin
    int k;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_req = 0;
        out_stall <= 0;
      end else begin
        k = pick_gap();
        if (k > 0) begin
          out_stall <= 1;
          repeat (k) @(posedge clk);
          out_stall <= 0;
        end
      end
    end
  end

  task automatic send_report(logic [62:0] now, lfr, lts, nfr, nts, logic [31:0] g);
    int k;
    in_valid <= 1;
    now_time_ns <= now; local_frames <= lfr; local_stamp_ns <= lts;
    net_frames <= nfr; net_stamp_ns <= nts; resync_generation <= g;
    do @(posedge clk); while (in_stall);
    k = pick_gap();
    if (k > 0) begin
      in_valid <= 0;
      repeat (k) @(posedge clk);
    end
  endtask

  // valid stays high across a burst of writes; the caller drops it
  task automatic cfg_write(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // block must be idle before a register write
  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic set_config(bit en, int sr, logic [31:0] rmin, rmax, int sabs, sdel,
                            int fast, slow);
    drain();
    cfg_write(CFG_ENABLE, 32'(en));
    cfg_write(CFG_RATE, sr);
    cfg_write(CFG_RATIO_MIN, rmin);
    cfg_write(CFG_RATIO_MAX, rmax);
    cfg_write(CFG_STAB_ABS, sabs);
    cfg_write(CFG_STAB_DELTA, sdel);
    cfg_write(CFG_FAST, fast);
    cfg_write(CFG_SLOW, slow);
    cfg_valid <= 0;
    cur_sr = sr; cur_fast = fast; cur_slow = slow;
  endtask

  // advance both clocks by dt seconds at nominal rate plus a ppm offset each
  task automatic clean_step(int dt_s, int ppm_l, int ppm_n);
    logic [63:0] dt, df;
    dt = 64'(dt_s) * 64'd1000000000 + $urandom_range(0, 1000000);
    t_now += dt;
    df = dt * 64'(cur_sr) / 64'd1000000000;
    l_fr += df + 64'(longint'(df) * ppm_l / 1000000);
    n_fr += df + 64'(longint'(df) * ppm_n / 1000000);
    l_ts += dt;
    n_ts += dt + $urandom_range(0, 1000);
    send_report(t_now[62:0], l_fr[62:0], l_ts[62:0], n_fr[62:0], n_ts[62:0], gen);
  endtask

  function automatic int due_s();
    return (cur_fast > cur_slow ? cur_fast : cur_slow) + 1;
  endfunction

  // resync to a new generation at the tracked time
  task automatic resync();
    gen = gen + 1 + $urandom_range(0, 3);
    t_now += 64'd1000000000;
    send_report(t_now[62:0], l_fr[62:0], l_ts[62:0], n_fr[62:0], n_ts[62:0], gen);
  endtask

  task automatic random_items(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) clean_step(due_s(), $urandom_range(0, 6) - 3, $urandom_range(0, 6) - 3);
      else if (r < 68) clean_step(due_s(), $urandom_range(0, 200) - 100,
                                  $urandom_range(0, 200) - 100);
      else if (r < 75) clean_step(due_s(), $urandom_range(0, 1) ? 80000 : -90000,
                                  $urandom_range(0, 20) - 10);
      else if (r < 81) clean_step(0, 0, 0);
      else if (r < 85) resync();
      else if (r < 91) begin
        // noise on every field, then resync to get back on track
        send_report(rand63(), rand63(), rand63(), rand63(), rand63(), $urandom);
        resync();
      end else if (r < 95) begin
        // stamps hold still
        t_now += 64'(due_s()) * 64'd1000000000;
        send_report(t_now[62:0], l_fr[62:0], l_ts[62:0], n_fr[62:0], n_ts[62:0], gen);
      end else begin
        // local frames run backwards
        l_fr -= 64'd1000;
        clean_step(due_s(), -2000000, 0);
      end
      if (i % 60 == 0) idle_on = ~idle_on;
    end
  endtask

  initial begin
    t_now = 64'd1000000000; l_ts = t_now; n_ts = t_now;
    l_fr = 64'd123456; n_fr = 64'd654321; gen = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: defaults, extremes and special windows
    set_config(1, 48000, 32'd1072668082, 32'd1074815566, 196608, 131072, 5, 30);
    send_report('0, '0, '0, '0, '0, '0);
    clean_step(due_s(), 0, 0);
    clean_step(due_s(), 1, -1);
    l_fr -= 64'd5;
    clean_step(due_s(), -1000000, 0);
    clean_step(due_s(), 0, 0);
    clean_step(due_s(), -2000000, 0);
    clean_step(due_s(), 0, 0);
    clean_step(due_s(), 90000, 0);
    t_now += 64'd40000000000;
    send_report(t_now[62:0], l_fr[62:0], l_ts[62:0], n_fr[62:0], n_ts[62:0], gen);
    clean_step(0, 0, 0);
    send_report('1, '1, '1, '1, '1, '1);
    resync();
    for (int i = 0; i < 10; i++) clean_step(due_s(), 2, -2);

    // random phases through several register settings
    random_items(300);
    set_config(1, 192000, 32'd0, 32'hFFFFFFFF, 6553600, 6553600, 1, 255);
    resync();
    random_items(100);
    hold_req = 1;
    random_items(200);
    set_config(1, 8000, 32'hFFFFFFFF, 32'd0, 0, 0, 255, 1);
    resync();
    random_items(250);
    set_config(0, 48000, 32'd1072668082, 32'd1074815566, 196608, 131072, 5, 30);
    random_items(80);
    set_config(1, 44100, 32'd1072668082, 32'd1074815566, 196608, 131072, 2, 3);
    resync();
    idle_on = 1;
    random_items(380);

    drain();
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #200000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
